// File: sv/ugpb_pkg.sv
// Shared types, field widths, command codes and defaults for the particle binning block.
package ugpb_pkg;

  // Default sizing, handed to the top level parameters.
  localparam int MAX_CELLS_DEF     = 4096;
  localparam int MAX_PARTICLES_DEF = 4096;
  localparam int POS_FRAC_BITS_DEF = 16;

  // Field widths fixed by the item formats.
  localparam int CMD_W      = 2;
  localparam int POS_W      = 32;
  localparam int ID_W       = 12;
  localparam int QRY_W      = 12;
  localparam int LINK_W     = 13;
  localparam int OUT_CELL_W = 12;
  localparam int INV_W      = 24;
  localparam int CELLS_W    = 13;

  // Fraction bits of the reciprocal cell size.
  localparam int INV_FRAC_BITS = 16;

  // Reciprocal scaling used to reduce a particle id modulo the particle count.
  localparam int RECIP_SH = 24;
  localparam int MP_W     = 17;

  // Depth of the queue between the front and back halves; a power of two.
  localparam int QUEUE_DEPTH = 4;

  // Configuration port.
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_INV_CELL = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_CELLS_X  = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_CELLS_Y  = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_CELLS_Z  = 3'd6;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NOP    = 2'd3;

  // Link value for an empty cell or a rejected request.
  localparam logic signed [LINK_W-1:0] LINK_NONE = '1;

  typedef struct packed {
    logic signed [POS_W-1:0] origin_x;
    logic signed [POS_W-1:0] origin_y;
    logic signed [POS_W-1:0] origin_z;
    logic [INV_W-1:0]        inv_cell_size;
    logic [CELLS_W-1:0]      cells_x;
    logic [CELLS_W-1:0]      cells_y;
    logic [CELLS_W-1:0]      cells_z;
  } cfg_t;

  typedef struct packed {
    logic [CMD_W-1:0]        cmd;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic [ID_W-1:0]         particle_id;
    logic [QRY_W-1:0]        query_cell;
  } in_item_t;

  typedef struct packed {
    logic signed [LINK_W-1:0] link;
    logic                     in_range;
    logic [OUT_CELL_W-1:0]    cell_out;
  } out_item_t;

  typedef struct packed {
    logic init_busy;
  } back_stat_t;

endpackage

// File: sv/ugpb_in_if.sv
// Input channel carrying one command beat with its position, particle id and query cell.
interface ugpb_in_if;
  import ugpb_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [CMD_W-1:0]        cmd;
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [POS_W-1:0] pos_z;
  logic [ID_W-1:0]         particle_id;
  logic [QRY_W-1:0]        query_cell;

  modport source (
    output valid, cmd, pos_x, pos_y, pos_z, particle_id, query_cell,
    input  ready
  );

  modport sink (
    input  valid, cmd, pos_x, pos_y, pos_z, particle_id, query_cell,
    output ready
  );
endinterface

// File: sv/ugpb_out_if.sv
// Result channel carrying one beat of link, range flag and cell index.
interface ugpb_out_if;
  import ugpb_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [LINK_W-1:0] link;
  logic                     in_range;
  logic [OUT_CELL_W-1:0]    cell_out;

  modport source (
    output valid, link, in_range, cell_out,
    input  ready
  );

  modport sink (
    input  valid, link, in_range, cell_out,
    output ready
  );
endinterface

// File: sv/ugpb_fifo.sv
// Short register queue between the address front end and the cell table back end.
module ugpb_fifo #(
  parameter int MAX_CELLS     = ugpb_pkg::MAX_CELLS_DEF,
  parameter int MAX_PARTICLES = ugpb_pkg::MAX_PARTICLES_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  logic [ugpb_pkg::CMD_W + $clog2(MAX_CELLS) + $clog2(MAX_PARTICLES):0] wdata,
  output logic full,
  input  logic pop,
  output logic [ugpb_pkg::CMD_W + $clog2(MAX_CELLS) + $clog2(MAX_PARTICLES):0] rdata,
  output logic empty
);
  import ugpb_pkg::*;

  localparam int W  = CMD_W + 1 + $clog2(MAX_CELLS) + $clog2(MAX_PARTICLES);
  localparam int AW = $clog2(QUEUE_DEPTH);

  logic [W-1:0]  slot_r [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full    = (cnt_r == (AW+1)'(QUEUE_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end
endmodule

// File: sv/ugpb_front.sv
// Front end: accepts command beats and turns positions into a range-checked linear cell index.
module ugpb_front #(
  parameter int MAX_CELLS     = ugpb_pkg::MAX_CELLS_DEF,
  parameter int MAX_PARTICLES = ugpb_pkg::MAX_PARTICLES_DEF,
  parameter int POS_FRAC_BITS = ugpb_pkg::POS_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ugpb_pkg::cfg_t     cfg,
  input  logic               hold,
  input  logic               in_valid,
  output logic               in_ready,
  input  ugpb_pkg::in_item_t in_item,
  output logic               q_push,
  output logic [ugpb_pkg::CMD_W + $clog2(MAX_CELLS) + $clog2(MAX_PARTICLES):0] q_wdata,
  input  logic               q_full
);
  import ugpb_pkg::*;

  localparam int CELL_AW = $clog2(MAX_CELLS);
  localparam int PID_W   = $clog2(MAX_PARTICLES);
  localparam int SHIFT   = POS_FRAC_BITS + INV_FRAC_BITS;
  localparam int DIFF_W  = POS_W + 1;
  localparam int SCALE_W = INV_W + 1;
  localparam int PROD_W  = DIFF_W + SCALE_W;
  localparam int G_W     = PROD_W - SHIFT;
  localparam int T4_W    = G_W + CELLS_W + 2;
  localparam int T5_W    = T4_W + CELLS_W + 2;
  localparam int CXY_W   = 2 * CELLS_W;
  localparam int TOT_W   = 3 * CELLS_W;
  localparam int PPROD_W = ID_W + RECIP_SH + 1;
  localparam int PQ_W    = PPROD_W - RECIP_SH;
  localparam int QM_W    = PQ_W + MP_W;
  localparam int RW      = MP_W + 1;
  localparam int NSTG    = 5;

  localparam logic [RECIP_SH:0] PID_RECIP = (RECIP_SH+1)'((1 << RECIP_SH) / MAX_PARTICLES);
  localparam logic [MP_W-1:0]   MP_K      = MP_W'(MAX_PARTICLES);

  // Scaled product to axis coordinate, truncated toward zero.
  function automatic logic signed [G_W-1:0] trunc_axis(input logic signed [PROD_W-1:0] p);
    logic [PROD_W-1:0] mag;
    logic [PROD_W-1:0] q;
    mag = p[PROD_W-1] ? $unsigned(-p) : $unsigned(p);
    q   = mag >> SHIFT;
    return p[PROD_W-1] ? -$signed(q[G_W-1:0]) : $signed(q[G_W-1:0]);
  endfunction

  logic [NSTG-1:0] vld_r;
  logic            en;

  // Stage 1
  logic [CMD_W-1:0]         cmd1_r;
  logic [QRY_W-1:0]         qry1_r;
  logic [ID_W-1:0]          pid1_r;
  logic [PPROD_W-1:0]       pidm1_r;
  logic signed [DIFF_W-1:0] dx1_r, dy1_r, dz1_r;
  logic [CXY_W-1:0]         cxy1_r;
  // Stage 2
  logic [CMD_W-1:0]         cmd2_r;
  logic [QRY_W-1:0]         qry2_r;
  logic [RW-1:0]            r2_r;
  logic signed [PROD_W-1:0] px2_r, py2_r, pz2_r;
  logic [TOT_W-1:0]         tot2_r;
  // Stage 3
  logic [CMD_W-1:0]         cmd3_r;
  logic [QRY_W-1:0]         qry3_r;
  logic [PID_W-1:0]         pid3_r;
  logic signed [G_W-1:0]    gx3_r, gy3_r, gz3_r;
  logic [TOT_W-1:0]         tot3_r;
  // Stage 4
  logic [CMD_W-1:0]         cmd4_r;
  logic [QRY_W-1:0]         qry4_r;
  logic [PID_W-1:0]         pid4_r;
  logic signed [G_W-1:0]    gx4_r;
  logic signed [T4_W-1:0]   t4_r;
  logic [TOT_W-1:0]         tot4_r;
  // Stage 5
  logic [CMD_W-1:0]         cmd5_r;
  logic [QRY_W-1:0]         qry5_r;
  logic [PID_W-1:0]         pid5_r;
  logic signed [T5_W-1:0]   t5_r;
  logic [TOT_W-1:0]         tot5_r;

  logic signed [SCALE_W-1:0]   inv_s;
  logic signed [CELLS_W:0]     cx_s, cy_s;
  logic [PQ_W-1:0]             pq;
  logic [QM_W-1:0]             qm;
  logic                        ins_ok, rd_ok, ok;
  logic [CELL_AW-1:0]          cell_idx;

  // The whole pipeline stalls only when its last stage cannot enter the queue.
  assign en       = !(vld_r[NSTG-1] && q_full);
  assign in_ready = en && !hold;
  assign q_push   = vld_r[NSTG-1] && !q_full;

  assign inv_s = $signed({1'b0, cfg.inv_cell_size});
  assign cx_s  = $signed({1'b0, cfg.cells_x});
  assign cy_s  = $signed({1'b0, cfg.cells_y});
  assign pq    = pidm1_r[PPROD_W-1:RECIP_SH];
  assign qm    = QM_W'(pq) * QM_W'(MP_K);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NSTG-2:0], in_valid && in_ready};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd1_r  <= in_item.cmd;
      qry1_r  <= in_item.query_cell;
      pid1_r  <= in_item.particle_id;
      pidm1_r <= PPROD_W'(in_item.particle_id) * PPROD_W'(PID_RECIP);
      dx1_r   <= DIFF_W'(in_item.pos_x) - DIFF_W'(cfg.origin_x);
      dy1_r   <= DIFF_W'(in_item.pos_y) - DIFF_W'(cfg.origin_y);
      dz1_r   <= DIFF_W'(in_item.pos_z) - DIFF_W'(cfg.origin_z);
      cxy1_r  <= CXY_W'(cfg.cells_x) * CXY_W'(cfg.cells_y);

      cmd2_r  <= cmd1_r;
      qry2_r  <= qry1_r;
      r2_r    <= RW'(pid1_r) - qm[RW-1:0];
      px2_r   <= PROD_W'(dx1_r) * PROD_W'(inv_s);
      py2_r   <= PROD_W'(dy1_r) * PROD_W'(inv_s);
      pz2_r   <= PROD_W'(dz1_r) * PROD_W'(inv_s);
      tot2_r  <= TOT_W'(cxy1_r) * TOT_W'(cfg.cells_z);

      cmd3_r  <= cmd2_r;
      qry3_r  <= qry2_r;
      pid3_r  <= (r2_r >= RW'(MP_K)) ? PID_W'(r2_r - RW'(MP_K)) : PID_W'(r2_r);
      gx3_r   <= trunc_axis(px2_r);
      gy3_r   <= trunc_axis(py2_r);
      gz3_r   <= trunc_axis(pz2_r);
      tot3_r  <= tot2_r;

      cmd4_r  <= cmd3_r;
      qry4_r  <= qry3_r;
      pid4_r  <= pid3_r;
      gx4_r   <= gx3_r;
      t4_r    <= T4_W'(gz3_r) * T4_W'(cy_s) + T4_W'(gy3_r);
      tot4_r  <= tot3_r;

      cmd5_r  <= cmd4_r;
      qry5_r  <= qry4_r;
      pid5_r  <= pid4_r;
      t5_r    <= T5_W'(t4_r) * T5_W'(cx_s) + T5_W'(gx4_r);
      tot5_r  <= tot4_r;
    end
  end

  // Only the linear total is range checked, never the separate axes.
  always_comb begin
    ins_ok = !t5_r[T5_W-1] && ($unsigned(t5_r) < T5_W'(tot5_r))
             && ($unsigned(t5_r) < T5_W'(MAX_CELLS));
    rd_ok  = (TOT_W'(qry5_r) < tot5_r) && (TOT_W'(qry5_r) < TOT_W'(MAX_CELLS));
    ok       = 1'b0;
    cell_idx = '0;
    case (cmd5_r)
      CMD_INSERT: begin
        ok       = ins_ok;
        cell_idx = t5_r[CELL_AW-1:0];
      end
      CMD_READ: begin
        ok       = rd_ok;
        cell_idx = CELL_AW'(qry5_r);
      end
      default: begin
        ok       = 1'b0;
        cell_idx = '0;
      end
    endcase
    if (!ok) begin
      cell_idx = '0;
    end
    q_wdata = {cmd5_r, ok, cell_idx, pid5_r};
  end
endmodule

// File: sv/ugpb_back.sv
// Back end: owns the cell head table, performs inserts, reads and clear sweeps, holds the result.
module ugpb_back #(
  parameter int MAX_CELLS     = ugpb_pkg::MAX_CELLS_DEF,
  parameter int MAX_PARTICLES = ugpb_pkg::MAX_PARTICLES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_empty,
  input  logic [ugpb_pkg::CMD_W + $clog2(MAX_CELLS) + $clog2(MAX_PARTICLES):0] q_rdata,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output ugpb_pkg::out_item_t  out_item,
  output ugpb_pkg::back_stat_t stat
);
  import ugpb_pkg::*;

  localparam int CELL_AW = $clog2(MAX_CELLS);
  localparam int PID_W   = $clog2(MAX_PARTICLES);
  localparam int ENT_W   = PID_W + 1;
  localparam int TOP     = CMD_W + CELL_AW + PID_W;

  localparam logic [CELL_AW-1:0] LAST_CELL = CELL_AW'(MAX_CELLS - 1);

  localparam logic [1:0] ST_INIT   = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_LOOKUP = 2'd2;
  localparam logic [1:0] ST_SWEEP  = 2'd3;

  // Each entry is {occupied, head}.
  logic [ENT_W-1:0] mem [MAX_CELLS];
  logic [ENT_W-1:0] rdata_r;

  logic [1:0]         state_r, state_nxt;
  logic [CELL_AW-1:0] sweep_r, sweep_nxt;
  logic [CELL_AW-1:0] cell_r, cell_nxt;
  logic [PID_W-1:0]   pid_r, pid_nxt;
  logic               ins_r, ins_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_item_r, out_item_nxt;

  logic [CMD_W-1:0]   q_op;
  logic               q_ok;
  logic [CELL_AW-1:0] q_cell;
  logic [PID_W-1:0]   q_pid;
  logic               out_free;
  logic               emit;
  out_item_t          emit_item;
  logic               mem_we, mem_re;
  logic [CELL_AW-1:0] mem_waddr;
  logic [ENT_W-1:0]   mem_wdata;

  assign q_op   = q_rdata[TOP -: CMD_W];
  assign q_ok   = q_rdata[CELL_AW + PID_W];
  assign q_cell = q_rdata[CELL_AW + PID_W - 1 -: CELL_AW];
  assign q_pid  = q_rdata[PID_W-1:0];

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign stat.init_busy = (state_r == ST_INIT);

  always_comb begin
    state_nxt = state_r;
    sweep_nxt = sweep_r;
    cell_nxt  = cell_r;
    pid_nxt   = pid_r;
    ins_nxt   = ins_r;
    q_pop     = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = sweep_r;
    mem_wdata = '0;
    emit      = 1'b0;
    emit_item.link     = LINK_NONE;
    emit_item.in_range = 1'b0;
    emit_item.cell_out = '0;
    case (state_r)
      ST_INIT: begin
        mem_we = 1'b1;
        if (sweep_r == LAST_CELL) begin
          sweep_nxt = '0;
          state_nxt = ST_IDLE;
        end else begin
          sweep_nxt = sweep_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (!q_empty) begin
          if (q_ok && (q_op == CMD_INSERT || q_op == CMD_READ)) begin
            q_pop     = 1'b1;
            mem_re    = 1'b1;
            cell_nxt  = q_cell;
            pid_nxt   = q_pid;
            ins_nxt   = (q_op == CMD_INSERT);
            state_nxt = ST_LOOKUP;
          end else if (q_op == CMD_CLEAR) begin
            q_pop     = 1'b1;
            sweep_nxt = '0;
            state_nxt = ST_SWEEP;
          end else if (out_free) begin
            q_pop = 1'b1;
            emit  = 1'b1;
          end
        end
      end
      ST_LOOKUP: begin
        if (out_free) begin
          emit = 1'b1;
          emit_item.link     = rdata_r[PID_W] ? LINK_W'(rdata_r[PID_W-1:0]) : LINK_NONE;
          emit_item.in_range = 1'b1;
          emit_item.cell_out = OUT_CELL_W'(cell_r);
          if (ins_r) begin
            mem_we    = 1'b1;
            mem_waddr = cell_r;
            mem_wdata = {1'b1, pid_r};
          end
          state_nxt = ST_IDLE;
        end
      end
      ST_SWEEP: begin
        mem_we = 1'b1;
        if (sweep_r == LAST_CELL) begin
          if (out_free) begin
            emit      = 1'b1;
            state_nxt = ST_IDLE;
          end
        end else begin
          sweep_nxt = sweep_r + 1'b1;
        end
      end
      default: begin
        state_nxt = ST_INIT;
      end
    endcase

    out_valid_nxt = emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
    out_item_nxt  = emit ? emit_item : out_item_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      sweep_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sweep_r     <= sweep_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cell_r     <= cell_nxt;
    pid_r      <= pid_nxt;
    ins_r      <= ins_nxt;
    out_item_r <= out_item_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[q_cell];
    end
  end
endmodule

// File: sv/uniform_grid_particle_binning_top.sv
// Top level of the uniform grid particle binning block: config registers, front, queue, back.
// An in-range insert or read goes through the back end's lookup state before its result is
// registered; a rejected or unused command skips it. The back end does the read-modify-write
// of one cell entry in its synchronous table per insert or read before the next command, so
// that port sets the rate. A clear sweeps the table one cell a cycle, the last waiting for a
// free result port; after reset the sweep covers every cell with the input channel not ready.
module uniform_grid_particle_binning_top #(
  parameter int MAX_CELLS     = ugpb_pkg::MAX_CELLS_DEF,
  parameter int MAX_PARTICLES = ugpb_pkg::MAX_PARTICLES_DEF,
  parameter int POS_FRAC_BITS = ugpb_pkg::POS_FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  ugpb_in_if.sink                     in_ch,
  ugpb_out_if.source                  out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ugpb_pkg::CFG_AW-1:0] paddr,
  input  logic [ugpb_pkg::CFG_DW-1:0] pwdata,
  output logic [ugpb_pkg::CFG_DW-1:0] prdata,
  output logic                        pready
);
  import ugpb_pkg::*;

  localparam int QW = CMD_W + 1 + $clog2(MAX_CELLS) + $clog2(MAX_PARTICLES);

  cfg_t             cfg_r;
  logic             cfg_wr;
  logic [REG_IDX_W-1:0] reg_idx;
  in_item_t         in_item;
  logic             in_ready;
  logic             q_push, q_full, q_pop, q_empty;
  logic [QW-1:0]    q_wdata, q_rdata;
  out_item_t        out_item;
  logic             out_valid;
  back_stat_t       back_stat;

  // The register port never waits. A write lands on the access beat; word addresses select
  // the register and addresses past the last register are ignored.
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = paddr[CFG_AW-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin_x      <= '0;
      cfg_r.origin_y      <= '0;
      cfg_r.origin_z      <= '0;
      cfg_r.inv_cell_size <= INV_W'(65536);
      cfg_r.cells_x       <= CELLS_W'(16);
      cfg_r.cells_y       <= CELLS_W'(16);
      cfg_r.cells_z       <= CELLS_W'(16);
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_ORIGIN_X: cfg_r.origin_x      <= $signed(pwdata);
        REG_ORIGIN_Y: cfg_r.origin_y      <= $signed(pwdata);
        REG_ORIGIN_Z: cfg_r.origin_z      <= $signed(pwdata);
        REG_INV_CELL: cfg_r.inv_cell_size <= pwdata[INV_W-1:0];
        REG_CELLS_X:  cfg_r.cells_x       <= pwdata[CELLS_W-1:0];
        REG_CELLS_Y:  cfg_r.cells_y       <= pwdata[CELLS_W-1:0];
        REG_CELLS_Z:  cfg_r.cells_z       <= pwdata[CELLS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Read-back of the register selected by the address.
  always_comb begin
    case (reg_idx)
      REG_ORIGIN_X: prdata = CFG_DW'(cfg_r.origin_x);
      REG_ORIGIN_Y: prdata = CFG_DW'(cfg_r.origin_y);
      REG_ORIGIN_Z: prdata = CFG_DW'(cfg_r.origin_z);
      REG_INV_CELL: prdata = CFG_DW'(cfg_r.inv_cell_size);
      REG_CELLS_X:  prdata = CFG_DW'(cfg_r.cells_x);
      REG_CELLS_Y:  prdata = CFG_DW'(cfg_r.cells_y);
      REG_CELLS_Z:  prdata = CFG_DW'(cfg_r.cells_z);
      default:      prdata = '0;
    endcase
  end

  // Gather the input beat into one payload word for the front end.
  assign in_item.cmd         = in_ch.cmd;
  assign in_item.pos_x       = in_ch.pos_x;
  assign in_item.pos_y       = in_ch.pos_y;
  assign in_item.pos_z       = in_ch.pos_z;
  assign in_item.particle_id = in_ch.particle_id;
  assign in_item.query_cell  = in_ch.query_cell;
  assign in_ch.ready         = in_ready;

  // The front end computes the cell index in a five stage pipeline and only stalls when
  // the queue is full; the input is held off while the back end is still clearing its
  // table after reset.
  ugpb_front #(
    .MAX_CELLS     (MAX_CELLS),
    .MAX_PARTICLES (MAX_PARTICLES),
    .POS_FRAC_BITS (POS_FRAC_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .hold     (back_stat.init_busy),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .q_push   (q_push),
    .q_wdata  (q_wdata),
    .q_full   (q_full)
  );

  // The queue decouples the two halves, so a long clear sweep or a stalled result port
  // does not stop the front end from accepting new beats until the queue fills.
  ugpb_fifo #(
    .MAX_CELLS     (MAX_CELLS),
    .MAX_PARTICLES (MAX_PARTICLES)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  // The back end owns the head table and the result register.
  ugpb_back #(
    .MAX_CELLS     (MAX_CELLS),
    .MAX_PARTICLES (MAX_PARTICLES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_rdata   (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .out_item  (out_item),
    .stat      (back_stat)
  );

  assign out_ch.valid    = out_valid;
  assign out_ch.link     = out_item.link;
  assign out_ch.in_range = out_item.in_range;
  assign out_ch.cell_out = out_item.cell_out;
endmodule
